>>> hw/rtl/dual_ir_debounce_classifier_defines.svh
// Assertion macros used by the checker file.
`ifndef DUAL_IR_DEBOUNCE_CLASSIFIER_DEFINES_SVH
`define DUAL_IR_DEBOUNCE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DIDBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DIDBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/didbc_pkg.sv
package didbc_pkg;

    // Dock state codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_LEFT     = 3'd1;
    localparam logic [2:0] ST_RIGHT    = 3'd2;
    localparam logic [2:0] ST_BOTH     = 3'd3;
    localparam logic [2:0] ST_UNSTABLE = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LOW     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNSTABLE_LIMIT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] DEBOUNCE_MS_RST    = 16'd50;
    localparam logic        ACTIVE_LOW_RST     = 1'b1;
    localparam logic [7:0]  UNSTABLE_LIMIT_RST = 8'd5;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic        left_level;
        logic        right_level;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0] dock_state;
        logic       left_seen;
        logic       right_seen;
    } result_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic        active_low;
        logic [7:0]  unstable_limit;
    } cfg_t;

    // Per-item control shared by the lanes and the merge stage
    typedef struct packed {
        logic take;
        logic primed;
    } step_t;

endpackage

>>> hw/rtl/didbc_lane.sv
module didbc_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  didbc_pkg::step_t   step,
    input  didbc_pkg::cfg_t    cfg,
    input  logic               level,
    input  logic [31:0]        now_ms,
    output logic               seen
);

    logic        prev_reg;
    logic        prev_next;
    logic        accepted_reg;
    logic        accepted_next;
    logic [31:0] change_time_reg;
    logic [31:0] change_time_next;
    logic        detected;
    logic [31:0] elapsed;

    // Apply polarity
    assign detected = level ^ cfg.active_low;

    // Track last change and accept a level that has held long enough
    always_comb
    begin
        prev_next        = prev_reg;
        accepted_next    = accepted_reg;
        change_time_next = change_time_reg;
        elapsed          = 32'd0;
        if (!step.primed)
        begin
            prev_next        = detected;
            accepted_next    = detected;
            change_time_next = now_ms;
        end
        else
        begin
            if (detected != prev_reg)
            begin
                change_time_next = now_ms;
            end
            prev_next = detected;
            elapsed   = now_ms - change_time_next;
            if (elapsed >= {16'd0, cfg.debounce_ms})
            begin
                accepted_next = detected;
            end
        end
    end

    // Advance lane state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg        <= 1'b0;
            accepted_reg    <= 1'b0;
            change_time_reg <= 32'd0;
        end
        else if (step.take)
        begin
            prev_reg        <= prev_next;
            accepted_reg    <= accepted_next;
            change_time_reg <= change_time_next;
        end
    end

    assign seen = accepted_next;

endmodule

>>> hw/rtl/didbc_merge.sv
module didbc_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  didbc_pkg::step_t   step,
    input  didbc_pkg::cfg_t    cfg,
    input  logic               left_seen,
    input  logic               right_seen,
    output logic [2:0]         dock_state
);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] count_inc;
    logic [2:0] cls;

    // Classify the debounced pair
    always_comb
    begin
        case ({left_seen, right_seen})
            2'b11:   cls = didbc_pkg::ST_BOTH;
            2'b10:   cls = didbc_pkg::ST_LEFT;
            2'b01:   cls = didbc_pkg::ST_RIGHT;
            default: cls = didbc_pkg::ST_NONE;
        endcase
    end

    // Count differing ticks, latch unstable at the limit
    always_comb
    begin
        count_inc  = (count_reg == didbc_pkg::COUNT_MAX) ? count_reg : count_reg + 8'd1;
        state_next = state_reg;
        count_next = count_reg;
        if (!step.primed)
        begin
            state_next = didbc_pkg::ST_NONE;
            count_next = 8'd0;
        end
        else if (cls != state_reg)
        begin
            count_next = count_inc;
            if (state_reg == didbc_pkg::ST_UNSTABLE || count_inc >= cfg.unstable_limit)
            begin
                state_next = didbc_pkg::ST_UNSTABLE;
            end
            else
            begin
                state_next = cls;
            end
        end
        else
        begin
            count_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= didbc_pkg::ST_NONE;
            count_reg <= 8'd0;
        end
        else if (step.take)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign dock_state = state_next;

endmodule

>>> hw/rtl/dual_ir_debounce_classifier.sv
// Debounces two IR receiver levels against a millisecond timestamp and reports
// the dock state (none, left, right, both, or a latched unstable) with the two
// debounced bits. Every accepted item yields exactly one result in the next
// cycle, from an output register. One item can be taken every cycle: the two
// channel lanes and the merge stage finish an item in combinational logic, and
// input stall rises only while a finished result is held by output stall.
// The first item after reset primes the block and reports none. Configuration
// writes take effect on the next item and are expected only while idle.
module dual_ir_debounce_classifier (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  didbc_pkg::item_t                       item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output didbc_pkg::result_t                     result,
    input  logic                                   cfg_we,
    input  logic [didbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [didbc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    didbc_pkg::cfg_t    cfg_reg;
    didbc_pkg::step_t   step;
    didbc_pkg::result_t result_reg;
    didbc_pkg::result_t result_next;
    logic               primed_reg;
    logic               valid_reg;
    logic               valid_next;
    logic               left_seen;
    logic               right_seen;
    logic [2:0]         dock_state;

    // Take a new item unless a finished result is stalled
    assign item_stall  = valid_reg & result_stall;
    assign step.take   = item_valid & ~item_stall;
    assign step.primed = primed_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= didbc_pkg::DEBOUNCE_MS_RST;
            cfg_reg.active_low     <= didbc_pkg::ACTIVE_LOW_RST;
            cfg_reg.unstable_limit <= didbc_pkg::UNSTABLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                didbc_pkg::CFG_DEBOUNCE_MS:    cfg_reg.debounce_ms    <= cfg_data;
                didbc_pkg::CFG_ACTIVE_LOW:     cfg_reg.active_low     <= cfg_data[0];
                didbc_pkg::CFG_UNSTABLE_LIMIT: cfg_reg.unstable_limit <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // Mark primed after the first transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
        end
        else if (step.take)
        begin
            primed_reg <= 1'b1;
        end
    end

    didbc_lane u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .level  (item.left_level),
        .now_ms (item.now_ms),
        .seen   (left_seen)
    );

    didbc_lane u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .level  (item.right_level),
        .now_ms (item.now_ms),
        .seen   (right_seen)
    );

    didbc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .left_seen  (left_seen),
        .right_seen (right_seen),
        .dock_state (dock_state)
    );

    // Build the result word
    always_comb
    begin
        result_next.dock_state = dock_state;
        result_next.left_seen  = left_seen;
        result_next.right_seen = right_seen;
    end

    // Hold the result until its transfer
    assign valid_next = step.take | (valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/didbc_checker.sv
`include "dual_ir_debounce_classifier_defines.svh"

module didbc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    input  logic                                   item_stall,
    input  logic                                   result_valid,
    input  logic                                   result_stall,
    input  didbc_pkg::result_t                     result
);

    logic unstable_seen_reg;
    logic unstable_seen_next;

    // Remember any unstable result shown since reset
    assign unstable_seen_next = unstable_seen_reg |
        (result_valid & (result.dock_state == didbc_pkg::ST_UNSTABLE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unstable_seen_reg <= 1'b0;
        end
        else
        begin
            unstable_seen_reg <= unstable_seen_next;
        end
    end

    // Stalled result holds
    `DIDBC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // Every transfer in gives a result next cycle
    `DIDBC_ASSERT_NEXT(a_result_follows, item_valid && !item_stall, result_valid, "accepted item gave no result")

    // No input taken over a stalled result
    `DIDBC_ASSERT_NOW(a_stall_back, result_valid && result_stall, item_stall, "input not stalled behind held result")

    // Unstable stays once reported
    `DIDBC_ASSERT_NOW(a_unstable_latch, result_valid && unstable_seen_reg, result.dock_state == didbc_pkg::ST_UNSTABLE, "unstable state was left")

endmodule

bind dual_ir_debounce_classifier didbc_checker u_didbc_checker (.*);
